// ===== hw/rtl/rgb2lab_pkg.sv =====
// ----------------------------------------------------------------------------
// rgb2lab_pkg
// Shared widths, word types and CIE axis constants for the RGB to Lab converter.
// ----------------------------------------------------------------------------
package rgb2lab_pkg;

  // Default depth of each f() table
  localparam int unsigned XYZ_TABLE_SIZE_DEF = 1024;

  localparam int CH_W     = 8;   // sRGB channel byte
  localparam int LIN_W    = 17;  // linear value, Q0.16 (1.0 is reachable)
  localparam int COEF_W   = 16;  // matrix coefficient, Q0.16
  localparam int XYZ_W    = 17;  // tristimulus, Q1.16
  localparam int F_W      = 17;  // f() table entry, Q0.16
  localparam int LAB_W    = 16;  // output, 1/256 units
  localparam int NUM_AXES = 3;

  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } rgb_word_t;

  typedef struct packed {
    logic signed [LAB_W-1:0] lightness;
    logic signed [LAB_W-1:0] green_red_axis;
    logic signed [LAB_W-1:0] blue_yellow_axis;
  } lab_word_t;

  typedef logic [NUM_AXES-1:0][XYZ_W-1:0] xyz_vec_t;
  typedef logic [NUM_AXES-1:0][F_W-1:0]   f_vec_t;

  // Full-scale value of each axis, times 1e6
  function automatic longint unsigned axis_max(int axis);
    case (axis)
      AXIS_X:  return 64'd950470;
      AXIS_Z:  return 64'd1088830;
      default: return 64'd1000000;
    endcase
  endfunction

  // D65 white point of each axis, times 1e6
  function automatic longint unsigned axis_white(int axis);
    case (axis)
      AXIS_X:  return 64'd950456;
      AXIS_Z:  return 64'd1088754;
      default: return 64'd1000000;
    endcase
  endfunction

  // Index scale 1e6/max written as 100000/div
  function automatic longint unsigned axis_div(int axis);
    case (axis)
      AXIS_X:  return 64'd95047;
      AXIS_Z:  return 64'd108883;
      default: return 64'd100000;
    endcase
  endfunction

endpackage

// ===== hw/rtl/rgb2lab_ram.sv =====
// ----------------------------------------------------------------------------
// rgb2lab_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rgb2lab_ram #(
  parameter int unsigned WIDTH = rgb2lab_pkg::F_W,
  parameter int unsigned DEPTH = rgb2lab_pkg::XYZ_TABLE_SIZE_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rgb2lab_xyz.sv =====
// ----------------------------------------------------------------------------
// rgb2lab_xyz
// Gamma linearization and 3x3 matrix to XYZ, three register stages.
// ----------------------------------------------------------------------------
module rgb2lab_xyz (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  rgb2lab_pkg::rgb_word_t pix_i,
  output rgb2lab_pkg::xyz_vec_t  xyz_o
);

  localparam int LIN_W  = rgb2lab_pkg::LIN_W;
  localparam int COEF_W = rgb2lab_pkg::COEF_W;
  localparam int XYZ_W  = rgb2lab_pkg::XYZ_W;
  localparam int CH_W   = rgb2lab_pkg::CH_W;
  localparam int NA     = rgb2lab_pkg::NUM_AXES;
  localparam int PROD_W = LIN_W + COEF_W;
  localparam int SUM_W  = PROD_W + 2;

  // Q30 x^5 with rounding at each step
  function automatic logic [63:0] pow5_q30(logic [63:0] r);
    logic [63:0] p;
    p = r;
    for (int k = 0; k < 4; k++) begin
      p = (p * r + (64'd1 << 29)) >> 30;
    end
    return p;
  endfunction

  // sRGB decode of one byte, Q0.16
  function automatic logic [LIN_W-1:0] gamma_entry(int unsigned v);
    logic [63:0] n, t, s, lo, hi, mid;
    if (v <= 10) begin
      return LIN_W'((64'd6553600 * 64'(v) + 64'd164730) / 64'd329460);
    end
    n  = 64'd40 * 64'(v) + 64'd561;
    t  = ((n << 30) + 64'd5380) / 64'd10761;
    s  = (t * t + (64'd1 << 29)) >> 30;
    lo = '0;
    hi = 64'd1 << 30;
    // floor fifth root of t^2, so lo ~ t^0.4
    for (int k = 0; k < 32; k++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (pow5_q30(mid) <= s) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    return LIN_W'((s * lo + (64'd1 << 43)) >> 44);
  endfunction

  function automatic logic [255:0][LIN_W-1:0] build_gamma();
    logic [255:0][LIN_W-1:0] tab;
    for (int v = 0; v < 256; v++) begin
      tab[v] = gamma_entry(v);
    end
    return tab;
  endfunction

  // sRGB to XYZ coefficients, Q0.16, row = axis
  function automatic logic [COEF_W-1:0] mat_coef(int a, int c);
    case (a * 3 + c)
      0:       return 16'd27031;
      1:       return 16'd23434;
      2:       return 16'd11825;
      3:       return 16'd13938;
      4:       return 16'd46868;
      5:       return 16'd4730;
      6:       return 16'd1267;
      7:       return 16'd7811;
      default: return 16'd62279;
    endcase
  endfunction

  localparam logic [255:0][LIN_W-1:0] GAMMA = build_gamma();

  logic [NA-1:0][CH_W-1:0]             chan;
  logic [NA-1:0][LIN_W-1:0]            lin_q;
  logic [NA-1:0][NA-1:0][PROD_W-1:0]   prod_q;
  logic [NA-1:0][SUM_W-1:0]            sum;
  logic [NA-1:0][XYZ_W-1:0]            xyz_q;

  assign chan = {pix_i.blue_in, pix_i.green_in, pix_i.red_in};

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      sum[a] = SUM_W'(prod_q[a][0]) + SUM_W'(prod_q[a][1]) + SUM_W'(prod_q[a][2])
             + SUM_W'(32768);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < NA; c++) begin
        lin_q[c] <= GAMMA[chan[c]];
      end
      for (int a = 0; a < NA; a++) begin
        for (int c = 0; c < NA; c++) begin
          prod_q[a][c] <= PROD_W'(lin_q[c]) * PROD_W'(mat_coef(a, c));
        end
        xyz_q[a] <= XYZ_W'(sum[a] >> 16);
      end
    end
  end

  assign xyz_o = xyz_q;

endmodule

// ===== hw/rtl/rgb2lab_index.sv =====
// ----------------------------------------------------------------------------
// rgb2lab_index
// Scales one XYZ value to a rounded, saturated f() table address.
// Constant division by reciprocal multiply plus one correction step.
// ----------------------------------------------------------------------------
module rgb2lab_index #(
  parameter int unsigned XYZ_TABLE_SIZE = rgb2lab_pkg::XYZ_TABLE_SIZE_DEF,
  parameter int          AXIS           = rgb2lab_pkg::AXIS_Y,
  localparam int         IDX_W          = $clog2(XYZ_TABLE_SIZE)
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [rgb2lab_pkg::XYZ_W-1:0]  xyz_i,
  output logic [IDX_W-1:0]               idx_o
);

  localparam int XYZ_W = rgb2lab_pkg::XYZ_W;

  // idx = floor(x / DIV), x = (xyz * (N-1) * 200000 + DIV * 65536) >> 17
  localparam longint unsigned DIV   = rgb2lab_pkg::axis_div(AXIS);
  localparam longint unsigned K     = 64'(XYZ_TABLE_SIZE - 1) * 64'd200000;
  localparam longint unsigned OFS   = DIV * 64'd65536;
  localparam longint unsigned X_MAX = (((64'd1 << XYZ_W) - 64'd1) * K + OFS) >> 17;
  localparam longint unsigned RECIP = (64'd1 << 47) / DIV;
  localparam int K_W  = $clog2(K + 1);
  localparam int P_W  = XYZ_W + K_W + 1;
  localparam int X_W  = $clog2(X_MAX + 1);
  localparam int R_W  = $clog2(RECIP + 1);
  localparam int M_W  = X_W + R_W;
  localparam int Q_W  = $clog2(X_MAX / DIV + 2);
  localparam int C_W  = X_W + 1;
  localparam int QS_W = Q_W + 1;

  logic [P_W-1:0]  scaled;
  logic [X_W-1:0]  x_q, x2_q;
  logic [M_W-1:0]  recip_prod;
  logic [Q_W-1:0]  q0_q;
  logic [C_W-1:0]  back_prod, rem;
  logic            carry;
  logic [QS_W-1:0] quot;

  assign scaled     = P_W'(xyz_i) * P_W'(K) + P_W'(OFS);
  assign recip_prod = M_W'(x_q) * M_W'(RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= X_W'(scaled >> 17);
      q0_q <= Q_W'(recip_prod >> 47);
      x2_q <= x_q;
    end
  end

  // estimate is exact or one low
  assign back_prod = C_W'(q0_q) * C_W'(DIV);
  assign rem       = C_W'(x2_q) - back_prod;
  assign carry     = (rem >= C_W'(DIV));
  assign quot      = QS_W'(q0_q) + QS_W'(carry);

  assign idx_o = (quot > QS_W'(XYZ_TABLE_SIZE - 1)) ? IDX_W'(XYZ_TABLE_SIZE - 1)
                                                    : IDX_W'(quot);

endmodule

// ===== hw/rtl/rgb2lab_ftab.sv =====
// ----------------------------------------------------------------------------
// rgb2lab_ftab
// Three f() lookup memories, one per axis, loaded by a sweep after reset.
// ----------------------------------------------------------------------------
module rgb2lab_ftab #(
  parameter int unsigned XYZ_TABLE_SIZE = rgb2lab_pkg::XYZ_TABLE_SIZE_DEF,
  localparam int         IDX_W          = $clog2(XYZ_TABLE_SIZE)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic [rgb2lab_pkg::NUM_AXES-1:0][IDX_W-1:0] idx_i,
  output rgb2lab_pkg::f_vec_t                   f_o,
  output logic                                  ready_o
);

  localparam int F_W = rgb2lab_pkg::F_W;
  localparam int NA  = rgb2lab_pkg::NUM_AXES;

  // Entry i: q = max*i / (N*white); cube root above the knee, linear below.
  // Divisions are done as searches against the denominator.
  function automatic logic [F_W-1:0] f_entry(int axis, int unsigned i);
    logic [127:0] num, den, lim, a_lin, b_lin, lo, hi, mid, y, cube;
    num = 128'(rgb2lab_pkg::axis_max(axis)) * 128'(i);
    den = 128'(XYZ_TABLE_SIZE) * 128'(rgb2lab_pkg::axis_white(axis));
    lo  = '0;
    hi  = 128'd1 << 17;
    if (num * 128'd1000000 <= 128'd8856 * den) begin
      a_lin = 128'd65536 * (128'd9033 * num + 128'd160 * den) + 128'd580 * den;
      b_lin = 128'd1160 * den;
      for (int k = 0; k < 20; k++) begin
        if (lo < hi) begin
          mid = (lo + hi + 128'd1) >> 1;
          if (mid * b_lin <= a_lin) begin
            lo = mid;
          end else begin
            hi = mid - 128'd1;
          end
        end
      end
    end else begin
      lim = num << 40;
      for (int k = 0; k < 20; k++) begin
        if (lo < hi) begin
          mid  = (lo + hi + 128'd1) >> 1;
          cube = mid * mid * mid;
          if (((cube + 128'd255) >> 8) * den <= lim) begin
            lo = mid;
          end else begin
            hi = mid - 128'd1;
          end
        end
      end
      // round to nearest
      y    = 128'd2 * lo + 128'd1;
      cube = y * y * y;
      if (((cube + 128'd2047) >> 11) * den <= lim) begin
        lo = lo + 128'd1;
      end
    end
    return F_W'(lo);
  endfunction

  function automatic logic [XYZ_TABLE_SIZE-1:0][F_W-1:0] build_f(int axis);
    logic [XYZ_TABLE_SIZE-1:0][F_W-1:0] tab;
    for (int i = 0; i < int'(XYZ_TABLE_SIZE); i++) begin
      tab[i] = f_entry(axis, i);
    end
    return tab;
  endfunction

  typedef enum logic {
    StLoad,
    StRun
  } state_e;

  state_e           state_q;
  logic [IDX_W-1:0] load_q;
  logic             ready_q;
  logic             load_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      load_q  <= '0;
      ready_q <= 1'b0;
    end else begin
      unique case (state_q)
        StLoad: begin
          load_q <= load_q + IDX_W'(1);
          if (load_q == IDX_W'(XYZ_TABLE_SIZE - 1)) begin
            state_q <= StRun;
            ready_q <= 1'b1;
          end
        end
        StRun: begin
          state_q <= StRun;
        end
      endcase
    end
  end

  assign load_we = (state_q == StLoad);
  assign ready_o = ready_q;

  for (genvar a = 0; a < NA; a++) begin : g_axis
    localparam logic [XYZ_TABLE_SIZE-1:0][F_W-1:0] TAB = build_f(a);

    rgb2lab_ram #(
      .WIDTH (F_W),
      .DEPTH (XYZ_TABLE_SIZE)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (load_we),
      .waddr_i (load_q),
      .wdata_i (TAB[load_q]),
      .re_i    (en_i),
      .raddr_i (idx_i[a]),
      .rdata_o (f_o[a])
    );
  end

endmodule

// ===== hw/rtl/rgb_to_lab_pixel_convert.sv =====
// ----------------------------------------------------------------------------
// rgb_to_lab_pixel_convert
// sRGB pixel to CIELAB (D65), table based, one pixel per clock unless stalled.
// ----------------------------------------------------------------------------
// Takes one 8-bit RGB word per clock while not stalled and returns L*, a*, b*
// as signed 16-bit values in units of 1/256, one result word per input word, in
// order. Every stage advances in the same cycle, so a new word is taken every
// clock while out_ready_i is high or the output register is empty; each word
// passes the pipeline stages listed below in order. After reset the three f()
// memories (XYZ_TABLE_SIZE entries each) are loaded one entry per cycle, and
// in_ready_o stays low until that load is done. The f() memories serve one
// lookup per axis per cycle, so they keep up with one word per clock.
//
// Pipeline:
//   1  gamma ROM per channel (256 entries, Q0.16)
//   2  nine constant products of the 3x3 matrix
//   3  row sums, rounded to XYZ in Q1.16
//   4  index scale, xyz * (N-1) * 200000 + offset
//   5  reciprocal multiply for the per-axis constant divide
//   6  correction and clamp, f() memory read (registered)
//   7  L = 116 fY - 16, a = 500 (fX - fY), b = 200 (fY - fZ), round, saturate
// ----------------------------------------------------------------------------
module rgb_to_lab_pixel_convert #(
  parameter int unsigned XYZ_TABLE_SIZE = rgb2lab_pkg::XYZ_TABLE_SIZE_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  rgb2lab_pkg::rgb_word_t in_word_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output rgb2lab_pkg::lab_word_t out_word_o
);

  localparam int IDX_W  = $clog2(XYZ_TABLE_SIZE);
  localparam int NA     = rgb2lab_pkg::NUM_AXES;
  localparam int LAB_W  = rgb2lab_pkg::LAB_W;
  localparam int PIPE_D = 6;   // stages before the output register
  localparam int ACC_W  = 28;  // wide enough for 500 * 2^17

  // round-to-nearest result, clipped to 16 bits
  function automatic logic signed [LAB_W-1:0] sat_lab(logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(32767)) begin
      return LAB_W'(32767);
    end else if (v < -ACC_W'(32768)) begin
      return LAB_W'(-32768);
    end
    return LAB_W'(v);
  endfunction

  logic                     advance;
  logic                     table_ready;
  logic [PIPE_D-1:0]        vld_q;
  logic                     out_vld_q;
  rgb2lab_pkg::lab_word_t   out_q, lab_d;
  rgb2lab_pkg::xyz_vec_t    xyz;
  rgb2lab_pkg::f_vec_t      f_val;
  logic [NA-1:0][IDX_W-1:0] idx;

  logic signed [ACC_W-1:0]  fx_s, fy_s, fz_s;
  logic signed [ACC_W-1:0]  l_raw, a_raw, b_raw;

  // Whole pipeline moves together; it holds only when the output word waits.
  assign advance    = !out_vld_q || out_ready_i;
  assign in_ready_o = table_ready && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      vld_q     <= {vld_q[PIPE_D-2:0], in_valid_i && table_ready};
      out_vld_q <= vld_q[PIPE_D-1];
    end
  end

  rgb2lab_xyz u_xyz (
    .clk_i (clk_i),
    .en_i  (advance),
    .pix_i (in_word_i),
    .xyz_o (xyz)
  );

  for (genvar a = 0; a < NA; a++) begin : g_index
    rgb2lab_index #(
      .XYZ_TABLE_SIZE (XYZ_TABLE_SIZE),
      .AXIS           (a)
    ) u_index (
      .clk_i (clk_i),
      .en_i  (advance),
      .xyz_i (xyz[a]),
      .idx_o (idx[a])
    );
  end

  rgb2lab_ftab #(
    .XYZ_TABLE_SIZE (XYZ_TABLE_SIZE)
  ) u_ftab (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .idx_i   (idx),
    .f_o     (f_val),
    .ready_o (table_ready)
  );

  // Lab from f() values, Q16 in, 1/256 out; >>> 8 floors toward -inf
  assign fx_s = signed'(ACC_W'(f_val[rgb2lab_pkg::AXIS_X]));
  assign fy_s = signed'(ACC_W'(f_val[rgb2lab_pkg::AXIS_Y]));
  assign fz_s = signed'(ACC_W'(f_val[rgb2lab_pkg::AXIS_Z]));

  assign l_raw = ACC_W'(116) * fy_s - ACC_W'(1048576) + ACC_W'(128);
  assign a_raw = ACC_W'(500) * (fx_s - fy_s) + ACC_W'(128);
  assign b_raw = ACC_W'(200) * (fy_s - fz_s) + ACC_W'(128);

  always_comb begin
    lab_d.lightness        = sat_lab(l_raw >>> 8);
    lab_d.green_red_axis   = sat_lab(a_raw >>> 8);
    lab_d.blue_yellow_axis = sat_lab(b_raw >>> 8);
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= lab_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule
